### rtl/float_noise_mask_codec_unit_macros.svh
// Assertion macros for the float noise mask codec
`ifndef FLOAT_NOISE_MASK_CODEC_UNIT_MACROS_SVH
`define FLOAT_NOISE_MASK_CODEC_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FNMC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FNMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fnmc_pkg.sv
// Package: types, constants and arithmetic helpers of the float noise mask codec
`timescale 1ns / 1ps
`default_nettype none
package fnmc_pkg;

  localparam int MANT_BITS  = 21;
  localparam int KEXP_BITS  = 10;
  localparam int IEXP_BITS  = 8;
  localparam int IMANT_BITS = 23;
  localparam int SIG_BITS   = IMANT_BITS + 1;
  localparam int QUO_BITS   = SIG_BITS + 2;
  localparam int DIV_STAGES = QUO_BITS / 2;

  localparam logic [KEXP_BITS-1:0] EXP_BIAS = KEXP_BITS'(127);
  localparam logic [KEXP_BITS-1:0] EXP_INF  = KEXP_BITS'(255);

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  localparam logic [1:0] CL_NUM  = 2'd0;
  localparam logic [1:0] CL_ZERO = 2'd1;
  localparam logic [1:0] CL_INF  = 2'd2;
  localparam logic [1:0] CL_NAN  = 2'd3;

  typedef struct packed {
    logic                  cmd;
    logic                  sgn;
    logic [1:0]            cls;
    logic [IEXP_BITS-1:0]  exf;   // effective exponent, 1 for subnormals
    logic [SIG_BITS-1:0]   rem;
    logic [QUO_BITS-1:0]   quo;
    logic [31:0]           enc;
  } stg_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [SIG_BITS:0] div_step(input logic [SIG_BITS-1:0] r,
                                                  input logic [SIG_BITS-1:0] m);
    logic [SIG_BITS:0] t;
    logic              q;
    logic [SIG_BITS:0] rn;
    t  = {r, 1'b0};
    q  = (t >= {1'b0, m});
    rn = q ? t - {1'b0, m} : t;
    return {q, rn[SIG_BITS-1:0]};
  endfunction

  // round to nearest even and pack; a carry out of the significand bumps the exponent
  function automatic logic [31:0] round_pack(input logic sgn,
                                             input logic [KEXP_BITS-1:0] base,
                                             input logic [SIG_BITS-1:0] sig,
                                             input logic g,
                                             input logic st);
    logic        up;
    logic [32:0] sum;
    up  = g & (st | sig[0]);
    sum = {base, {IMANT_BITS{1'b0}}} + 33'(sig) + 33'(up);
    if (sum[32:IMANT_BITS] >= EXP_INF) return {sgn, INF_MAG};
    return {sgn, sum[30:0]};
  endfunction

endpackage
`default_nettype wire

### rtl/float_noise_mask_codec_unit.sv
// Top level: pipelined binary32 masking (multiply) and unmasking (divide) by a keyed factor
// Accepts one item per cycle.
// Depth is set by the divider: 26 restoring steps, two per stage over 13 stages.
// busy is never raised; each result is shown for one cycle with out_valid.
// Synchronous active-low reset clears the valid bits and the key (to 0).
// Data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "float_noise_mask_codec_unit_macros.svh"
module float_noise_mask_codec_unit
  import fnmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  output logic [31:0]      out_result,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] key_r;
  logic        s0_vld_r;
  logic        s0_cmd_r;
  logic [31:0] s0_x_r;
  logic [DIV_STAGES-1:0] vld_r;
  stg_t        stg_r [DIV_STAGES];
  stg_t        stg_nxt [DIV_STAGES];
  logic [2*SIG_BITS-1:0] prod_r;
  logic        out_valid_r;
  logic [31:0] out_result_r;

  logic [SIG_BITS-1:0]  key_m;
  logic [KEXP_BITS-1:0] key_e;
  logic [KEXP_BITS-1:0] dexp;
  logic [31:0]          x_nxt;

  assign key_m = {1'b1, key_r[MANT_BITS-1:0], 2'b00};
  assign key_e = key_r[30:MANT_BITS];
  assign busy  = 1'b0;

  // decrypt rebuilds a binary32 word from the ciphertext before it enters
  assign dexp  = in_value[30:MANT_BITS] - key_e + EXP_BIAS;
  assign x_nxt = (in_cmd == CMD_DEC) ?
                 {in_value[31], dexp[IEXP_BITS-1:0], in_value[MANT_BITS-1:0], 2'b00} :
                 in_value;

  // stage 1: unpack, multiply, first two quotient bits
  logic [IEXP_BITS-1:0]  s1_exp;
  logic [IMANT_BITS-1:0] s1_frac;
  logic [SIG_BITS-1:0]   s1_sig;
  logic                  s1_q25;
  logic [SIG_BITS-1:0]   s1_r;
  logic [SIG_BITS:0]     s1_step;
  stg_t                  s1_nxt;

  always_comb begin
    s1_exp  = s0_x_r[30:IMANT_BITS];
    s1_frac = s0_x_r[IMANT_BITS-1:0];
    s1_sig  = {s1_exp != '0, s1_frac};
    s1_q25  = (s1_sig >= key_m);
    s1_r    = s1_q25 ? s1_sig - key_m : s1_sig;
    s1_step = div_step(s1_r, key_m);
    s1_nxt.cmd = s0_cmd_r;
    s1_nxt.sgn = s0_x_r[31] ^ key_r[31];
    if (s1_exp == '1) begin
      s1_nxt.cls = (s1_frac != '0) ? CL_NAN : CL_INF;
    end else if (s1_exp == '0 && s1_frac == '0) begin
      s1_nxt.cls = CL_ZERO;
    end else begin
      s1_nxt.cls = CL_NUM;
    end
    s1_nxt.exf = (s1_exp == '0) ? IEXP_BITS'(1) : s1_exp;
    s1_nxt.rem = s1_step[SIG_BITS-1:0];
    s1_nxt.quo = {{(QUO_BITS-2){1'b0}}, s1_q25, s1_step[SIG_BITS]};
    s1_nxt.enc = '0;
  end

  // stage 2: encrypt rounding and two division steps; later stages: two division steps each
  logic                 e_p47;
  logic [SIG_BITS-1:0]  e_sig;
  logic                 e_g;
  logic                 e_st;
  logic [KEXP_BITS-1:0] e_base;
  logic [31:0]          e_p;
  logic [KEXP_BITS-1:0] e_exp;

  always_comb begin
    e_p47  = prod_r[2*SIG_BITS-1];
    e_sig  = e_p47 ? prod_r[47:24] : prod_r[46:23];
    e_g    = e_p47 ? prod_r[23] : prod_r[22];
    e_st   = e_p47 ? (prod_r[22:0] != '0) : (prod_r[21:0] != '0);
    e_base = KEXP_BITS'(stg_r[0].exf) - KEXP_BITS'(1) + KEXP_BITS'(e_p47);
    case (stg_r[0].cls)
      CL_NAN:  e_p = QNAN_BITS;
      CL_INF:  e_p = {stg_r[0].sgn, INF_MAG};
      CL_ZERO: e_p = {stg_r[0].sgn, 31'd0};
      default: e_p = round_pack(stg_r[0].sgn, e_base, e_sig, e_g, e_st);
    endcase
    e_exp = KEXP_BITS'(e_p[30:IMANT_BITS]) + key_e - EXP_BIAS;
  end

  logic [SIG_BITS:0] st_a [1:DIV_STAGES-1];
  logic [SIG_BITS:0] st_b [1:DIV_STAGES-1];

  always_comb begin
    stg_nxt[0] = s1_nxt;
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_a[k] = div_step(stg_r[k-1].rem, key_m);
      st_b[k] = div_step(st_a[k][SIG_BITS-1:0], key_m);
      stg_nxt[k]     = stg_r[k-1];
      stg_nxt[k].rem = st_b[k][SIG_BITS-1:0];
      stg_nxt[k].quo = {stg_r[k-1].quo[QUO_BITS-3:0], st_a[k][SIG_BITS], st_b[k][SIG_BITS]};
    end
    stg_nxt[1].enc = {e_p[31], e_exp, e_p[IMANT_BITS-1:2]};
  end

  // output stage: decrypt rounding and result select
  stg_t                 lst;
  logic                 d_sh2;
  logic [SIG_BITS-1:0]  d_sig;
  logic                 d_g;
  logic                 d_st;
  logic [KEXP_BITS-1:0] d_base;
  logic [31:0]          d_q;
  logic [31:0]          out_result_nxt;

  always_comb begin
    lst    = stg_r[DIV_STAGES-1];
    // quotient in [1,2) or a subnormal result keeps the coarse alignment
    d_sh2  = lst.quo[QUO_BITS-1] | (lst.exf == IEXP_BITS'(1));
    d_sig  = d_sh2 ? lst.quo[25:2] : lst.quo[24:1];
    d_g    = d_sh2 ? lst.quo[1] : lst.quo[0];
    d_st   = (d_sh2 & lst.quo[0]) | (lst.rem != '0);
    if (lst.quo[QUO_BITS-1]) begin
      d_base = KEXP_BITS'(lst.exf) - KEXP_BITS'(1);
    end else if (lst.exf == IEXP_BITS'(1)) begin
      d_base = '0;
    end else begin
      d_base = KEXP_BITS'(lst.exf) - KEXP_BITS'(2);
    end
    case (lst.cls)
      CL_NAN:  d_q = QNAN_BITS;
      CL_INF:  d_q = {lst.sgn, INF_MAG};
      CL_ZERO: d_q = {lst.sgn, 31'd0};
      default: d_q = round_pack(lst.sgn, d_base, d_sig, d_g, d_st);
    endcase
    out_result_nxt = (lst.cmd == CMD_DEC) ? d_q : lst.enc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      s0_vld_r    <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) key_r <= cfg_data;
      s0_vld_r    <= start;
      vld_r       <= {vld_r[DIV_STAGES-2:0], s0_vld_r};
      out_valid_r <= vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    s0_cmd_r <= in_cmd;
    s0_x_r   <= x_nxt;
    prod_r   <= s1_sig * key_m;
    for (int k = 0; k < DIV_STAGES; k++) begin
      stg_r[k] <= stg_nxt[k];
    end
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `FNMC_ASSERT_NEXT(a_enter, start && !busy, s0_vld_r, "accepted item did not enter the pipe")
  `FNMC_ASSERT_NEXT(a_leave, vld_r[DIV_STAGES-1], out_valid, "item lost before the output")
  `FNMC_ASSERT_IMPLY(a_nostall, busy, 1'b0, "pipe must never hold off input")

endmodule
`default_nettype wire

### test/fnmc_checker.sv
// Checker for the float noise mask codec: predicts each result and compares it
`timescale 1ns / 1ps
`default_nettype none
module fnmc_checker
  import fnmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_value,
  input  wire logic        out_valid,
  input  wire logic [31:0] out_result,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               checked
);

  logic [31:0] key_q;
  logic [31:0] want_q[$];

  // binary32 bits widened to a double
  function automatic real f32_to_real(input logic [31:0] b);
    logic [63:0] d;
    logic [7:0]  e;
    logic [23:0] f;
    int          k;
    e = b[30:23];
    f = {1'b0, b[22:0]};
    k = 0;
    if (e == 8'hFF)
      d = (f != 0) ? 64'h7FF8_0000_0000_0000 : {b[31], 11'h7FF, 52'h0};
    else if (e == 0 && f == 0)
      d = {b[31], 63'h0};
    else if (e == 0) begin
      while (!f[23]) begin
        f = f << 1;
        k++;
      end
      d = {b[31], 11'(1023 - 126 - k), f[22:0], 29'h0};
    end else
      d = {b[31], 11'(int'(e) - 127 + 1023), f[22:0], 29'h0};
    return $bitstoreal(d);
  endfunction

  // double rounded to binary32, nearest even, NaN made canonical
  function automatic logic [31:0] real_to_f32(input real r);
    logic [63:0] d;
    logic [63:0] sig, mant, lost, half;
    logic [31:0] base, sum;
    int          e, sh;
    logic        up;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNAN_BITS : {d[63], INF_MAG};
    if (d[62:52] == 0) return {d[63], 31'h0};
    e   = int'(d[62:52]) - 1023 + 127;
    sig = {11'h0, 1'b1, d[51:0]};
    sh  = (e >= 1) ? 29 : 29 + 1 - e;
    if (sh > 54) return {d[63], 31'h0};
    mant = sig >> sh;
    lost = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    up   = (lost > half) || (lost == half && mant[0]);
    base = (e >= 1) ? 32'(e - 1) << 23 : 32'h0;
    sum  = base + 32'(mant) + 32'(up);
    if (sum >= 32'h7F80_0000) return {d[63], INF_MAG};
    return {d[63], sum[30:0]};
  endfunction

  function automatic real mask_factor(input logic [31:0] k);
    return f32_to_real({k[31], 8'd127, k[20:0], 2'b00});
  endfunction

  function automatic logic [31:0] masked_word(input logic cmd, input logic [31:0] v,
                                              input logic [31:0] k);
    logic [31:0] p, x;
    logic [9:0]  ex;
    logic [7:0]  ix;
    if (cmd == CMD_ENC) begin
      p  = real_to_f32(f32_to_real(v) * mask_factor(k));
      ex = 10'(p[30:23]) + k[30:21] - 10'd127;
      return {p[31], ex, p[22:2]};
    end
    ix = 8'(v[30:21] - k[30:21] + 10'd127);
    x  = {v[31], ix, v[20:0], 2'b00};
    return real_to_f32(f32_to_real(x) / mask_factor(k));
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    logic [31:0] w;
    if (!rst_n) begin
      key_q      <= 32'h0;
      fail_count <= 0;
      checked    <= 0;
    end else begin
      if (out_valid) begin
        if (want_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %08h", out_result);
        end else begin
          w = want_q.pop_front();
          checked <= checked + 1;
          if (w !== out_result) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("result mismatch: expected %08h got %08h", w, out_result);
          end
        end
      end
      if (start && !busy) want_q.push_back(masked_word(in_cmd, in_value, key_q));
      if (cfg_we) key_q <= cfg_data;
    end
  end

endmodule
`default_nettype wire

### test/tb_float_noise_mask_codec_unit.sv
// Testbench top: stimulus, key phases and verdict for the float noise mask codec
`timescale 1ns / 1ps
`default_nettype none
module tb_float_noise_mask_codec_unit;
  import fnmc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_cmd = CMD_ENC;
  logic [31:0] in_value = 32'h0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = 32'h0;
  wire         busy, out_valid;
  wire  [31:0] out_result;
  int          fail_count, pending, checked;
  int          n_items = 0;
  logic        steady = 1'b0;

  always #5 clk = ~clk;

  float_noise_mask_codec_unit dut (.*);

  fnmc_checker chk (.*);

  // one item, with a random gap before it unless in the steady stretch
  task automatic send_item(input logic cmd, input logic [31:0] v);
    while (!steady && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    @(negedge clk);
  endtask

  // drain, let the pipe empty, then load a new key
  task automatic load_key(input logic [31:0] k);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= k;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'(254 - $urandom_range(3));
      3: v[30:23] = 8'(1 + $urandom_range(3));
      default: ;
    endcase
    return v;
  endfunction

  logic [31:0] edge_vals[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
    32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
    32'h7F7F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'h7FFF_FFFF};
  logic [31:0] keys[8] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h001F_FFFF, 32'h0FE0_0000, 32'h0, 32'h0, 32'h0};

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (edge_vals[i]) send_item(CMD_ENC, edge_vals[i]);
    foreach (edge_vals[i]) send_item(CMD_DEC, edge_vals[i]);
    for (int ph = 0; ph < 9; ph++) begin
      if (ph > 0) load_key(ph < 6 ? keys[ph - 1] : $urandom);
      for (int i = 0; i < 210; i++) begin
        steady = (ph == 3 && i < 120);
        if ($urandom_range(1)) send_item(CMD_ENC, rand_float());
        else send_item(CMD_DEC, $urandom);
      end
    end
    steady = 1'b0;
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("%0d items sent over 9 keys incl. zero, all-ones and sign-only; %0d checked",
             n_items, checked);
    if (fail_count == 0) $display("tb_float_noise_mask_codec_unit passed");
    else $display("tb_float_noise_mask_codec_unit failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_float_noise_mask_codec_unit failed");
    $finish;
  end

endmodule
`default_nettype wire
